@@ design/mss_pkg.sv @@
// ----------------------------------------------------------------------------
// mss_pkg
// Shared types, constants, microcode store and dispatch tables of the small
// mips-like core.
// ----------------------------------------------------------------------------
package mss_pkg;

  // memory geometry (byte memory depth is a power of two, addresses wrap)
  localparam int MEM_BYTES = 4096;
  localparam int MEM_AW    = $clog2(MEM_BYTES);
  localparam int NUM_REGS  = 32;
  localparam int RF_AW     = $clog2(NUM_REGS);

  // payload widths
  localparam int REQ_W  = 3;
  localparam int ADDR_W = 12;
  localparam int WORD_W = 32;
  localparam int SEL_W  = 5;

  // request codes
  localparam logic [REQ_W-1:0] REQ_WRITE_WORD = 3'd0;
  localparam logic [REQ_W-1:0] REQ_START      = 3'd1;
  localparam logic [REQ_W-1:0] REQ_STEP       = 3'd2;
  localparam logic [REQ_W-1:0] REQ_READ_REG   = 3'd3;
  localparam logic [REQ_W-1:0] REQ_READ_WORD  = 3'd4;

  // instruction selectors
  localparam logic [5:0] OP_LI     = 6'b101111;
  localparam logic [5:0] OP_ADD_LB = 6'b100000;
  localparam logic [5:0] OP_BGE    = 6'b000101;
  localparam logic [5:0] OP_LW     = 6'b100011;
  localparam logic [5:0] OP_SW     = 6'b101011;
  localparam logic [5:0] OP_ADDI   = 6'b001000;
  localparam logic [5:0] OP_J      = 6'b000010;
  localparam logic [5:0] OP_SPECIAL = 6'b000000;

  // micro-program addresses
  localparam int UPC_W = 6;
  localparam logic [UPC_W-1:0] U_IDLE     = 6'd0;
  localparam logic [UPC_W-1:0] U_FIN_ZERO = 6'd1;
  localparam logic [UPC_W-1:0] U_FIN_RF   = 6'd2;
  localparam logic [UPC_W-1:0] U_FIN_WORD = 6'd3;
  localparam logic [UPC_W-1:0] U_W0       = 6'd4;
  localparam logic [UPC_W-1:0] U_W1       = 6'd5;
  localparam logic [UPC_W-1:0] U_W2       = 6'd6;
  localparam logic [UPC_W-1:0] U_W3       = 6'd7;
  localparam logic [UPC_W-1:0] U_ST0      = 6'd8;
  localparam logic [UPC_W-1:0] U_X0       = 6'd9;
  localparam logic [UPC_W-1:0] U_X1       = 6'd10;
  localparam logic [UPC_W-1:0] U_X2       = 6'd11;
  localparam logic [UPC_W-1:0] U_X3       = 6'd12;
  localparam logic [UPC_W-1:0] U_X4       = 6'd13;
  localparam logic [UPC_W-1:0] U_X5       = 6'd14;
  localparam logic [UPC_W-1:0] U_X6       = 6'd15;
  localparam logic [UPC_W-1:0] U_X7       = 6'd16;
  localparam logic [UPC_W-1:0] U_HLT      = 6'd17;
  localparam logic [UPC_W-1:0] U_LI       = 6'd18;
  localparam logic [UPC_W-1:0] U_ADD0     = 6'd19;
  localparam logic [UPC_W-1:0] U_ADD1     = 6'd20;
  localparam logic [UPC_W-1:0] U_LB0      = 6'd21;
  localparam logic [UPC_W-1:0] U_LB1      = 6'd22;
  localparam logic [UPC_W-1:0] U_LB2      = 6'd23;
  localparam logic [UPC_W-1:0] U_BGE      = 6'd24;
  localparam logic [UPC_W-1:0] U_LW0      = 6'd25;
  localparam logic [UPC_W-1:0] U_LW1      = 6'd26;
  localparam logic [UPC_W-1:0] U_LW2      = 6'd27;
  localparam logic [UPC_W-1:0] U_LW3      = 6'd28;
  localparam logic [UPC_W-1:0] U_LW4      = 6'd29;
  localparam logic [UPC_W-1:0] U_LW5      = 6'd30;
  localparam logic [UPC_W-1:0] U_LW6      = 6'd31;
  localparam logic [UPC_W-1:0] U_SW0      = 6'd32;
  localparam logic [UPC_W-1:0] U_SW1      = 6'd33;
  localparam logic [UPC_W-1:0] U_SW2      = 6'd34;
  localparam logic [UPC_W-1:0] U_SW3      = 6'd35;
  localparam logic [UPC_W-1:0] U_SW4      = 6'd36;
  localparam logic [UPC_W-1:0] U_ADDI0    = 6'd37;
  localparam logic [UPC_W-1:0] U_ADDI1    = 6'd38;
  localparam logic [UPC_W-1:0] U_J        = 6'd39;
  localparam logic [UPC_W-1:0] U_FLT      = 6'd40;
  localparam logic [UPC_W-1:0] U_RR0      = 6'd41;
  localparam logic [UPC_W-1:0] U_RW0      = 6'd42;
  localparam logic [UPC_W-1:0] U_RW1      = 6'd43;
  localparam logic [UPC_W-1:0] U_RW2      = 6'd44;
  localparam logic [UPC_W-1:0] U_RW3      = 6'd45;
  localparam logic [UPC_W-1:0] U_RW4      = 6'd46;

  // control word fields
  typedef enum logic [2:0] {
    SEQ_NEXT, SEQ_JUMP, SEQ_WAIT, SEQ_DISP_OP, SEQ_DONE, SEQ_IF_STOP, SEQ_IF_ZERO
  } seq_t;
  typedef enum logic [1:0] {MA_PC, MA_REQ, MA_ALU} maddr_t;
  typedef enum logic {MWD_REQ, MWD_B} mwd_t;
  typedef enum logic [1:0] {RRA_RS, RRA_RT, RRA_SEL} rra_t;
  typedef enum logic [1:0] {ALU_NONE, ALU_ADD_B, ALU_ADD_IMM} alu_t;
  typedef enum logic {RWA_RT, RWA_RD} rwa_t;
  typedef enum logic [1:0] {RWD_IMM, RWD_ALU, RWD_WORD, RWD_BYTE} rwd_t;
  typedef enum logic [2:0] {PC_KEEP, PC_INC4, PC_BGE, PC_JUMP, PC_START} pcop_t;
  typedef enum logic [1:0] {RD_ZERO, RD_RF, RD_WORD} rdsel_t;

  typedef struct packed {
    seq_t             seq;
    logic [UPC_W-1:0] target;
    logic             mem_rd;
    logic             mem_wr;
    maddr_t           maddr;
    logic [1:0]       moff;
    mwd_t             mwd;
    logic             sh_ins;
    logic             sh_word;
    logic             rf_rd;
    rra_t             rra;
    logic             ld_a;
    logic             ld_b;
    alu_t             alu;
    logic             rf_wr;
    rwa_t             rwa;
    rwd_t             rwd;
    pcop_t            pc_op;
    logic             set_halt;
    logic             set_fault;
    logic             clr_flags;
    rdsel_t           rdsel;
  } ctrl_t;

  // microcode store
  function automatic ctrl_t ucode_rom(input logic [UPC_W-1:0] upc);
    ctrl_t c;
    c = '0;
    unique case (upc)
      U_IDLE:     c.seq = SEQ_WAIT;
      U_FIN_ZERO: begin c.seq = SEQ_DONE; c.rdsel = RD_ZERO; end
      U_FIN_RF:   begin c.seq = SEQ_DONE; c.rdsel = RD_RF; end
      U_FIN_WORD: begin c.seq = SEQ_DONE; c.rdsel = RD_WORD; end
      // host word write, one byte a step
      U_W0: begin c.mem_wr = 1'b1; c.maddr = MA_REQ; c.moff = 2'd0; end
      U_W1: begin c.mem_wr = 1'b1; c.maddr = MA_REQ; c.moff = 2'd1; end
      U_W2: begin c.mem_wr = 1'b1; c.maddr = MA_REQ; c.moff = 2'd2; end
      U_W3: begin
        c.mem_wr = 1'b1; c.maddr = MA_REQ; c.moff = 2'd3;
        c.seq = SEQ_JUMP; c.target = U_FIN_ZERO;
      end
      U_ST0: begin
        c.pc_op = PC_START; c.clr_flags = 1'b1;
        c.seq = SEQ_JUMP; c.target = U_FIN_ZERO;
      end
      // fetch
      U_X0: begin
        c.mem_rd = 1'b1; c.maddr = MA_PC; c.moff = 2'd0;
        c.seq = SEQ_IF_STOP; c.target = U_FIN_ZERO;
      end
      U_X1: begin c.mem_rd = 1'b1; c.maddr = MA_PC; c.moff = 2'd1; c.sh_ins = 1'b1; end
      U_X2: begin c.mem_rd = 1'b1; c.maddr = MA_PC; c.moff = 2'd2; c.sh_ins = 1'b1; end
      U_X3: begin c.mem_rd = 1'b1; c.maddr = MA_PC; c.moff = 2'd3; c.sh_ins = 1'b1; end
      U_X4: c.sh_ins = 1'b1;
      // operand read and decode
      U_X5: begin
        c.rf_rd = 1'b1; c.rra = RRA_RS;
        c.seq = SEQ_IF_ZERO; c.target = U_HLT;
      end
      U_X6: begin c.rf_rd = 1'b1; c.rra = RRA_RT; c.ld_a = 1'b1; c.pc_op = PC_INC4; end
      U_X7: begin c.ld_b = 1'b1; c.seq = SEQ_DISP_OP; end
      U_HLT: begin c.set_halt = 1'b1; c.seq = SEQ_JUMP; c.target = U_FIN_ZERO; end
      U_LI: begin
        c.rf_wr = 1'b1; c.rwa = RWA_RT; c.rwd = RWD_IMM;
        c.seq = SEQ_JUMP; c.target = U_FIN_ZERO;
      end
      U_ADD0: c.alu = ALU_ADD_B;
      U_ADD1: begin
        c.rf_wr = 1'b1; c.rwa = RWA_RD; c.rwd = RWD_ALU;
        c.seq = SEQ_JUMP; c.target = U_FIN_ZERO;
      end
      U_LB0: c.alu = ALU_ADD_IMM;
      U_LB1: begin c.mem_rd = 1'b1; c.maddr = MA_ALU; c.moff = 2'd0; end
      U_LB2: begin
        c.rf_wr = 1'b1; c.rwa = RWA_RT; c.rwd = RWD_BYTE;
        c.seq = SEQ_JUMP; c.target = U_FIN_ZERO;
      end
      U_BGE: begin c.pc_op = PC_BGE; c.seq = SEQ_JUMP; c.target = U_FIN_ZERO; end
      U_LW0: c.alu = ALU_ADD_IMM;
      U_LW1: begin c.mem_rd = 1'b1; c.maddr = MA_ALU; c.moff = 2'd0; end
      U_LW2: begin c.mem_rd = 1'b1; c.maddr = MA_ALU; c.moff = 2'd1; c.sh_word = 1'b1; end
      U_LW3: begin c.mem_rd = 1'b1; c.maddr = MA_ALU; c.moff = 2'd2; c.sh_word = 1'b1; end
      U_LW4: begin c.mem_rd = 1'b1; c.maddr = MA_ALU; c.moff = 2'd3; c.sh_word = 1'b1; end
      U_LW5: c.sh_word = 1'b1;
      U_LW6: begin
        c.rf_wr = 1'b1; c.rwa = RWA_RT; c.rwd = RWD_WORD;
        c.seq = SEQ_JUMP; c.target = U_FIN_ZERO;
      end
      U_SW0: c.alu = ALU_ADD_IMM;
      U_SW1: begin c.mem_wr = 1'b1; c.maddr = MA_ALU; c.moff = 2'd0; c.mwd = MWD_B; end
      U_SW2: begin c.mem_wr = 1'b1; c.maddr = MA_ALU; c.moff = 2'd1; c.mwd = MWD_B; end
      U_SW3: begin c.mem_wr = 1'b1; c.maddr = MA_ALU; c.moff = 2'd2; c.mwd = MWD_B; end
      U_SW4: begin
        c.mem_wr = 1'b1; c.maddr = MA_ALU; c.moff = 2'd3; c.mwd = MWD_B;
        c.seq = SEQ_JUMP; c.target = U_FIN_ZERO;
      end
      U_ADDI0: c.alu = ALU_ADD_IMM;
      U_ADDI1: begin
        c.rf_wr = 1'b1; c.rwa = RWA_RT; c.rwd = RWD_ALU;
        c.seq = SEQ_JUMP; c.target = U_FIN_ZERO;
      end
      U_J:   begin c.pc_op = PC_JUMP; c.seq = SEQ_JUMP; c.target = U_FIN_ZERO; end
      U_FLT: begin c.set_fault = 1'b1; c.seq = SEQ_JUMP; c.target = U_FIN_ZERO; end
      // host register read
      U_RR0: begin
        c.rf_rd = 1'b1; c.rra = RRA_SEL;
        c.seq = SEQ_JUMP; c.target = U_FIN_RF;
      end
      // host word read
      U_RW0: begin c.mem_rd = 1'b1; c.maddr = MA_REQ; c.moff = 2'd0; end
      U_RW1: begin c.mem_rd = 1'b1; c.maddr = MA_REQ; c.moff = 2'd1; c.sh_word = 1'b1; end
      U_RW2: begin c.mem_rd = 1'b1; c.maddr = MA_REQ; c.moff = 2'd2; c.sh_word = 1'b1; end
      U_RW3: begin c.mem_rd = 1'b1; c.maddr = MA_REQ; c.moff = 2'd3; c.sh_word = 1'b1; end
      U_RW4: begin c.sh_word = 1'b1; c.seq = SEQ_JUMP; c.target = U_FIN_WORD; end
      default: begin c.seq = SEQ_JUMP; c.target = U_IDLE; end
    endcase
    return c;
  endfunction

  // dispatch on request type
  function automatic logic [UPC_W-1:0] req_entry(input logic [REQ_W-1:0] req);
    logic [UPC_W-1:0] e;
    unique case (req)
      REQ_WRITE_WORD: e = U_W0;
      REQ_START:      e = U_ST0;
      REQ_STEP:       e = U_X0;
      REQ_READ_REG:   e = U_RR0;
      REQ_READ_WORD:  e = U_RW0;
      default:        e = U_FIN_ZERO;
    endcase
    return e;
  endfunction

  // dispatch on instruction selector
  function automatic logic [UPC_W-1:0] op_entry(input logic [WORD_W-1:0] ins);
    logic [5:0]       op;
    logic [5:0]       sel;
    logic [UPC_W-1:0] e;
    op  = ins[31:26];
    sel = (op == OP_SPECIAL) ? ins[5:0] : op;
    unique case (sel)
      OP_LI:     e = U_LI;
      OP_ADD_LB: e = (op == OP_SPECIAL) ? U_ADD0 : U_LB0;
      OP_BGE:    e = U_BGE;
      OP_LW:     e = U_LW0;
      OP_SW:     e = U_SW0;
      OP_ADDI:   e = U_ADDI0;
      OP_J:      e = U_J;
      default:   e = U_FLT;
    endcase
    return e;
  endfunction

endpackage

@@ design/mss_if.sv @@
// ----------------------------------------------------------------------------
// mss channel interfaces
// Request, result and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------

// request channel
interface mss_req_if;
  logic                        valid;
  logic                        ready;
  logic [mss_pkg::REQ_W-1:0]   req_type;
  logic [mss_pkg::ADDR_W-1:0]  mem_address;
  logic [mss_pkg::WORD_W-1:0]  write_data;
  logic [mss_pkg::SEL_W-1:0]   reg_select;
  modport source(output valid, req_type, mem_address, write_data, reg_select,
                 input ready);
  modport sink(input valid, req_type, mem_address, write_data, reg_select,
               output ready);
endinterface

// result channel
interface mss_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [mss_pkg::WORD_W-1:0]  read_data;
  logic [mss_pkg::WORD_W-1:0]  pc_value;
  logic                        halted;
  logic                        fault;
  modport source(output valid, read_data, pc_value, halted, fault, input ready);
  modport sink(input valid, read_data, pc_value, halted, fault, output ready);
endinterface

// configuration write channel
interface mss_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [mss_pkg::ADDR_W-1:0]  code_start;
  modport source(output valid, code_start, input ready);
  modport sink(input valid, code_start, output ready);
endinterface

@@ design/mips_subset_cpu_step.sv @@
// ----------------------------------------------------------------------------
// mips_subset_cpu_step
// Microcoded mips-like core: byte memory, register file and pc driven by a
// control store, one request in and one result out per transfer.
// ----------------------------------------------------------------------------
// latency is longest for a step on lw: four byte fetches plus four byte loads
// the core takes a new request only in its idle step, once the previous result is
//   loaded; all byte accesses share the single-port byte memory
// reset: a clearing pass over all 4096 memory bytes zeroes memory and registers; no request
//   transfer meanwhile, configuration writes still taken
module mips_subset_cpu_step (
  input logic        clk,
  input logic        rst_n,
  mss_req_if.sink    in_chan,
  mss_rsp_if.source  out_chan,
  mss_cfg_if.sink    cfg_chan
);

  // storage
  logic [7:0]                   mem [mss_pkg::MEM_BYTES];
  logic [mss_pkg::WORD_W-1:0]   rf  [mss_pkg::NUM_REGS];

  logic [mss_pkg::UPC_W-1:0]    upc_r, upc_nxt;
  logic                         clr_busy_r;
  logic [mss_pkg::MEM_AW-1:0]   clr_cnt_r;
  logic [mss_pkg::ADDR_W-1:0]   code_start_r;
  logic [mss_pkg::WORD_W-1:0]   pc_r, pc_nxt;
  logic                         halt_r, fault_r;
  logic [mss_pkg::WORD_W-1:0]   ins_r, word_r, a_r, b_r, alu_r;
  logic [7:0]                   mem_q_r;
  logic [mss_pkg::WORD_W-1:0]   rf_q_r;
  logic [mss_pkg::ADDR_W-1:0]   req_addr_r;
  logic [mss_pkg::WORD_W-1:0]   req_wdata_r;
  logic [mss_pkg::SEL_W-1:0]    req_sel_r;

  logic                         out_valid_r;
  logic [mss_pkg::WORD_W-1:0]   out_rdata_r, out_pc_r;
  logic                         out_halt_r, out_fault_r;

  mss_pkg::ctrl_t               cw;
  logic                         in_accept, stall, out_load;
  logic [15:0]                  imm;
  logic [mss_pkg::WORD_W-1:0]   base, wsrc, rf_wdata;
  logic [mss_pkg::MEM_AW-1:0]   mem_addr;
  logic                         mem_we, mem_re;
  logic [7:0]                   mem_wdata;
  logic [mss_pkg::RF_AW-1:0]    rf_raddr, rf_waddr;
  logic                         rf_we;

  // control word of the current step
  assign cw        = mss_pkg::ucode_rom(upc_r);
  assign imm       = ins_r[15:0];
  assign in_accept = in_chan.valid & in_chan.ready;
  assign stall     = (cw.seq == mss_pkg::SEQ_DONE) & out_valid_r & ~out_chan.ready;
  assign out_load  = (cw.seq == mss_pkg::SEQ_DONE) & ~stall;

  assign in_chan.ready  = ~clr_busy_r & (upc_r == mss_pkg::U_IDLE);
  assign cfg_chan.ready = 1'b1;

  // sequencer
  always_comb begin
    unique case (cw.seq)
      mss_pkg::SEQ_NEXT:    upc_nxt = upc_r + 1'b1;
      mss_pkg::SEQ_JUMP:    upc_nxt = cw.target;
      mss_pkg::SEQ_WAIT:    upc_nxt = in_accept ? mss_pkg::req_entry(in_chan.req_type)
                                                : upc_r;
      mss_pkg::SEQ_DISP_OP: upc_nxt = mss_pkg::op_entry(ins_r);
      mss_pkg::SEQ_DONE:    upc_nxt = stall ? upc_r : mss_pkg::U_IDLE;
      mss_pkg::SEQ_IF_STOP: upc_nxt = (halt_r | fault_r) ? cw.target : upc_r + 1'b1;
      mss_pkg::SEQ_IF_ZERO: upc_nxt = (ins_r == '0) ? cw.target : upc_r + 1'b1;
      default:              upc_nxt = mss_pkg::U_IDLE;
    endcase
  end

  // memory address and byte write data (addresses wrap at the memory size)
  always_comb begin
    unique case (cw.maddr)
      mss_pkg::MA_PC:  base = pc_r;
      mss_pkg::MA_REQ: base = {{(mss_pkg::WORD_W-mss_pkg::ADDR_W){1'b0}}, req_addr_r};
      default:         base = alu_r;
    endcase
    wsrc = (cw.mwd == mss_pkg::MWD_B) ? b_r : req_wdata_r;
    unique case (cw.moff)
      2'd0:    mem_wdata = wsrc[7:0];
      2'd1:    mem_wdata = wsrc[15:8];
      2'd2:    mem_wdata = wsrc[23:16];
      default: mem_wdata = wsrc[31:24];
    endcase
    mem_addr = clr_busy_r ? clr_cnt_r
                          : base[mss_pkg::MEM_AW-1:0] + mss_pkg::MEM_AW'(cw.moff);
    mem_we   = clr_busy_r | cw.mem_wr;
    mem_re   = ~clr_busy_r & cw.mem_rd;
  end

  // byte memory, single port, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= clr_busy_r ? 8'd0 : mem_wdata;
    end
    if (mem_re) begin
      mem_q_r <= mem[mem_addr];
    end
  end

  // register file ports
  always_comb begin
    unique case (cw.rra)
      mss_pkg::RRA_RS: rf_raddr = ins_r[25:21];
      mss_pkg::RRA_RT: rf_raddr = ins_r[20:16];
      default:         rf_raddr = req_sel_r;
    endcase
    unique case (cw.rwd)
      mss_pkg::RWD_IMM:  rf_wdata = {16'd0, imm};
      mss_pkg::RWD_ALU:  rf_wdata = alu_r;
      mss_pkg::RWD_WORD: rf_wdata = word_r;
      default:           rf_wdata = {{24{mem_q_r[7]}}, mem_q_r};
    endcase
    if (clr_busy_r) begin
      rf_waddr = clr_cnt_r[mss_pkg::RF_AW-1:0];
    end else begin
      rf_waddr = (cw.rwa == mss_pkg::RWA_RD) ? ins_r[15:11] : ins_r[20:16];
    end
    rf_we = clr_busy_r | cw.rf_wr;
  end

  always_ff @(posedge clk) begin
    if (rf_we) begin
      rf[rf_waddr] <= clr_busy_r ? '0 : rf_wdata;
    end
    if (cw.rf_rd) begin
      rf_q_r <= rf[rf_raddr];
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      req_addr_r  <= in_chan.mem_address;
      req_wdata_r <= in_chan.write_data;
      req_sel_r   <= in_chan.reg_select;
    end
    if (cw.sh_ins) begin
      ins_r <= {mem_q_r, ins_r[31:8]};
    end
    if (cw.sh_word) begin
      word_r <= {mem_q_r, word_r[31:8]};
    end
    if (cw.ld_a) begin
      a_r <= rf_q_r;
    end
    if (cw.ld_b) begin
      b_r <= rf_q_r;
    end
    if (cw.alu == mss_pkg::ALU_ADD_B) begin
      alu_r <= a_r + b_r;
    end else if (cw.alu == mss_pkg::ALU_ADD_IMM) begin
      alu_r <= a_r + {16'd0, imm};
    end
  end

  // program counter update
  always_comb begin
    unique case (cw.pc_op)
      mss_pkg::PC_INC4:  pc_nxt = pc_r + 32'd4;
      mss_pkg::PC_BGE:   pc_nxt = ($signed(a_r) >= $signed(b_r))
                                  ? pc_r + {14'd0, imm, 2'b00} : pc_r;
      mss_pkg::PC_JUMP:  pc_nxt = {4'd0, ins_r[25:0], 2'b00};
      mss_pkg::PC_START: pc_nxt = {{(mss_pkg::WORD_W-mss_pkg::ADDR_W){1'b0}}, code_start_r};
      default:           pc_nxt = pc_r;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r        <= mss_pkg::U_IDLE;
      clr_busy_r   <= 1'b1;
      clr_cnt_r    <= '0;
      code_start_r <= '0;
      pc_r         <= '0;
      halt_r       <= 1'b0;
      fault_r      <= 1'b0;
    end else begin
      upc_r <= upc_nxt;
      pc_r  <= pc_nxt;
      if (clr_busy_r) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
        if (clr_cnt_r == mss_pkg::MEM_AW'(mss_pkg::MEM_BYTES - 1)) begin
          clr_busy_r <= 1'b0;
        end
      end
      if (cfg_chan.valid) begin
        code_start_r <= cfg_chan.code_start;
      end
      if (cw.clr_flags) begin
        halt_r  <= 1'b0;
        fault_r <= 1'b0;
      end
      if (cw.set_halt) begin
        halt_r <= 1'b1;
      end
      if (cw.set_fault) begin
        fault_r <= 1'b1;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      unique case (cw.rdsel)
        mss_pkg::RD_RF:   out_rdata_r <= rf_q_r;
        mss_pkg::RD_WORD: out_rdata_r <= word_r;
        default:          out_rdata_r <= '0;
      endcase
      out_pc_r    <= pc_r;
      out_halt_r  <= halt_r;
      out_fault_r <= fault_r;
    end
  end

  assign out_chan.valid     = out_valid_r;
  assign out_chan.read_data = out_rdata_r;
  assign out_chan.pc_value  = out_pc_r;
  assign out_chan.halted    = out_halt_r;
  assign out_chan.fault     = out_fault_r;

  // a dispatched request always leaves the idle step
  a_leave_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> (upc_r != mss_pkg::U_IDLE))
    else $error("sequencer stayed idle after a request transfer");

  // halt only rises out of the halt step
  a_halt_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(halt_r) |-> ($past(upc_r) == mss_pkg::U_HLT))
    else $error("halt flag set outside the halt step");

  // fault only rises out of the unknown-selector step
  a_fault_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(fault_r) |-> ($past(upc_r) == mss_pkg::U_FLT))
    else $error("fault flag set outside the fault step");

  // clearing pass ends only after the last memory entry
  a_clear_end: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(clr_busy_r) |->
      ($past(clr_cnt_r) == mss_pkg::MEM_AW'(mss_pkg::MEM_BYTES - 1)))
    else $error("clearing pass ended early");

endmodule

@@ tb/tb_mips_subset_cpu_step.sv @@
// ----------------------------------------------------------------------------
// tb_mips_subset_cpu_step
// Self-checking bench for the small mips-like core. Requests go in over the
// valid/ready request channel, and a behavioural copy of the core predicts
// every result. Directed checks cover host access, each instruction,
// halting and one long result stall. Random instruction streams then run
// from several code start addresses, mostly with idle cycles on both sides.
// ----------------------------------------------------------------------------
module tb_mips_subset_cpu_step;

  // request codes with no effect in the core
  localparam logic [mss_pkg::REQ_W-1:0] REQ_UNUSED_LO = 3'd5;
  localparam logic [mss_pkg::REQ_W-1:0] REQ_UNUSED_HI = 3'd7;
  localparam logic [5:0]                OP_UNKNOWN    = 6'b111111;
  localparam int                        ITEM_TARGET   = 1820;
  localparam int                        HOLD_CYCLES   = 300;

  typedef struct packed {
    logic [mss_pkg::WORD_W-1:0] read_data;
    logic [mss_pkg::WORD_W-1:0] pc_value;
    logic                       halted;
    logic                       fault;
  } response_t;

  logic clk = 1'b0;
  logic rst_n;

  mss_req_if req_ch();
  mss_rsp_if rsp_ch();
  mss_cfg_if cfg_ch();

  mips_subset_cpu_step dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (req_ch),
    .out_chan (rsp_ch),
    .cfg_chan (cfg_ch)
  );

  // behavioural copy of the core
  logic [7:0]                 core_mem  [mss_pkg::MEM_BYTES];
  logic [mss_pkg::WORD_W-1:0] core_regs [mss_pkg::NUM_REGS];
  logic [mss_pkg::WORD_W-1:0] core_pc;
  logic                       core_halted;
  logic                       core_faulted;
  logic [mss_pkg::ADDR_W-1:0] code_start_reg;

  response_t expected_responses[$];
  int        error_count = 0;
  int        items_sent  = 0;
  int        gap_pct     = 10;
  logic      hold_off;
  event      hold_start;

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  function automatic int unsigned byte_slot(input logic [mss_pkg::WORD_W-1:0] a);
    return a % 32'(mss_pkg::MEM_BYTES);
  endfunction

  // little-endian word, each byte address wraps on its own
  function automatic logic [mss_pkg::WORD_W-1:0] core_load_word(
      input logic [mss_pkg::WORD_W-1:0] a);
    logic [mss_pkg::WORD_W-1:0] w;
    w = '0;
    for (int i = 3; i >= 0; i--)
      w = {w[23:0], core_mem[byte_slot(a + 32'(i))]};
    return w;
  endfunction

  function automatic void core_store_word(input logic [mss_pkg::WORD_W-1:0] a,
                                          input logic [mss_pkg::WORD_W-1:0] w);
    for (int i = 0; i < 4; i++)
      core_mem[byte_slot(a + 32'(i))] = w[8*i +: 8];
  endfunction

  function automatic void core_execute();
    logic [mss_pkg::WORD_W-1:0] ins;
    logic [mss_pkg::WORD_W-1:0] imm;
    logic [mss_pkg::WORD_W-1:0] tgt;
    logic [5:0]                 op;
    logic [5:0]                 sel;
    logic [4:0]                 rs;
    logic [4:0]                 rt;
    logic [4:0]                 rd;
    logic [7:0]                 by;
    ins = core_load_word(core_pc);
    // zero word halts without moving the pc
    if (ins == '0) begin
      core_halted = 1'b1;
      return;
    end
    op  = ins[31:26];
    sel = (op == mss_pkg::OP_SPECIAL) ? ins[5:0] : op;
    rs  = ins[25:21];
    rt  = ins[20:16];
    rd  = ins[15:11];
    imm = {16'h0000, ins[15:0]};
    tgt = {6'h00, ins[25:0]};
    core_pc = core_pc + 32'd4;
    case (sel)
      mss_pkg::OP_LI: core_regs[rt] = imm;
      mss_pkg::OP_ADD_LB: begin
        if (op == mss_pkg::OP_SPECIAL) begin
          core_regs[rd] = core_regs[rs] + core_regs[rt];
        end else begin
          by = core_mem[byte_slot(core_regs[rs] + imm)];
          core_regs[rt] = {{24{by[7]}}, by};
        end
      end
      mss_pkg::OP_BGE: begin
        if ($signed(core_regs[rs]) >= $signed(core_regs[rt]))
          core_pc = core_pc + (imm << 2);
      end
      mss_pkg::OP_LW:   core_regs[rt] = core_load_word(core_regs[rs] + imm);
      mss_pkg::OP_SW:   core_store_word(core_regs[rs] + imm, core_regs[rt]);
      mss_pkg::OP_ADDI: core_regs[rt] = core_regs[rs] + imm;
      mss_pkg::OP_J:    core_pc = tgt << 2;
      default:          core_faulted = 1'b1;
    endcase
  endfunction

  function automatic void predict_response(input logic [mss_pkg::REQ_W-1:0]  kind,
                                           input logic [mss_pkg::ADDR_W-1:0] addr,
                                           input logic [mss_pkg::WORD_W-1:0] data,
                                           input logic [mss_pkg::SEL_W-1:0]  rsel);
    response_t r;
    r.read_data = '0;
    case (kind)
      mss_pkg::REQ_WRITE_WORD: core_store_word({20'h00000, addr}, data);
      mss_pkg::REQ_START: begin
        core_pc      = {20'h00000, code_start_reg};
        core_halted  = 1'b0;
        core_faulted = 1'b0;
      end
      mss_pkg::REQ_STEP: begin
        if (!core_halted && !core_faulted)
          core_execute();
      end
      mss_pkg::REQ_READ_REG:  r.read_data = core_regs[rsel];
      mss_pkg::REQ_READ_WORD: r.read_data = core_load_word({20'h00000, addr});
      default: ;
    endcase
    r.pc_value = core_pc;
    r.halted   = core_halted;
    r.fault    = core_faulted;
    expected_responses.push_back(r);
  endfunction

  // ---------------------------------------------------------------------------
  // instruction encoding
  // ---------------------------------------------------------------------------

  function automatic bit known_selector(input logic [5:0] s);
    return s inside {mss_pkg::OP_LI, mss_pkg::OP_ADD_LB, mss_pkg::OP_BGE, mss_pkg::OP_LW,
                     mss_pkg::OP_SW, mss_pkg::OP_ADDI, mss_pkg::OP_J};
  endfunction

  // mostly valid instructions with random fields, a few faults and halts
  function automatic logic [mss_pkg::WORD_W-1:0] random_instruction(
      input logic [mss_pkg::ADDR_W-1:0] base,
      input int                         words);
    logic [5:0]  op;
    logic [5:0]  fn;
    logic [4:0]  rs;
    logic [4:0]  rt;
    logic [4:0]  rd;
    logic [15:0] imm;
    logic [25:0] tgt;
    int          pick;
    rs   = 5'($urandom);
    rt   = 5'($urandom);
    rd   = 5'($urandom);
    imm  = 16'($urandom);
    pick = $urandom_range(99);
    if (pick < 12) return {mss_pkg::OP_LI, rs, rt, imm};
    if (pick < 24)
      return {mss_pkg::OP_SPECIAL, rs, rt, rd, 5'($urandom), mss_pkg::OP_ADD_LB};
    if (pick < 34) return {mss_pkg::OP_ADD_LB, rs, rt, imm};
    if (pick < 46) begin
      // short branches keep the stream inside the program
      if ($urandom_range(7) != 0) imm = 16'($urandom_range(3));
      return {mss_pkg::OP_BGE, rs, rt, imm};
    end
    if (pick < 58) return {mss_pkg::OP_LW, rs, rt, imm};
    if (pick < 70) return {mss_pkg::OP_SW, rs, rt, imm};
    if (pick < 82) return {mss_pkg::OP_ADDI, rs, rt, imm};
    if (pick < 88) begin
      tgt = 26'(base >> 2) + 26'($urandom_range(words));
      if ($urandom_range(7) == 0) tgt = 26'($urandom);
      return {mss_pkg::OP_J, tgt};
    end
    if (pick < 94) begin
      // selector taken from funct under opcode zero
      case ($urandom_range(5))
        0:       fn = mss_pkg::OP_LI;
        1:       fn = mss_pkg::OP_LW;
        2:       fn = mss_pkg::OP_SW;
        3:       fn = mss_pkg::OP_ADDI;
        4:       fn = mss_pkg::OP_J;
        default: fn = mss_pkg::OP_BGE;
      endcase
      return {mss_pkg::OP_SPECIAL, rs, rt, rd, 5'($urandom), fn};
    end
    if (pick < 98) begin
      if ($urandom_range(1) == 0) begin
        do op = 6'($urandom); while (op == mss_pkg::OP_SPECIAL || known_selector(op));
        return {op, 26'($urandom)};
      end
      do fn = 6'($urandom); while (known_selector(fn));
      return {mss_pkg::OP_SPECIAL, rs, rt, rd, 5'($urandom), fn};
    end
    return '0;
  endfunction

  // ---------------------------------------------------------------------------
  // channel drivers
  // ---------------------------------------------------------------------------

  // one request transfer; valid stays high afterwards until the next call
  task automatic send_request(input logic [mss_pkg::REQ_W-1:0]  kind,
                              input logic [mss_pkg::ADDR_W-1:0] addr,
                              input logic [mss_pkg::WORD_W-1:0] data,
                              input logic [mss_pkg::SEL_W-1:0]  rsel);
    while ($urandom_range(99) < gap_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid       <= 1'b1;
    req_ch.req_type    <= kind;
    req_ch.mem_address <= addr;
    req_ch.write_data  <= data;
    req_ch.reg_select  <= rsel;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    predict_response(kind, addr, data, rsel);
    items_sent++;
  endtask

  task automatic send_random_fields(input logic [mss_pkg::REQ_W-1:0] kind);
    send_request(kind, mss_pkg::ADDR_W'($urandom), $urandom, mss_pkg::SEL_W'($urandom));
  endtask

  // stop offering and wait until every result is back
  task automatic drain_responses();
    req_ch.valid <= 1'b0;
    while (expected_responses.size() != 0) @(posedge clk);
  endtask

  task automatic write_code_start(input logic [mss_pkg::ADDR_W-1:0] value);
    drain_responses();
    cfg_ch.valid      <= 1'b1;
    cfg_ch.code_start <= value;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    code_start_reg = value;
    cfg_ch.valid <= 1'b0;
  endtask

  // long hold-off of the result side, counted here in cycles
  initial begin
    hold_off <= 1'b0;
    @(hold_start);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  // result sink with random stalls and the long hold-off
  always @(posedge clk) begin
    if (!rst_n || hold_off) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= ($urandom_range(99) >= gap_pct);
    end
  end

  // compare each result transfer with the oldest prediction
  always @(posedge clk) begin
    response_t want;
    if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
      if (expected_responses.size() == 0) begin
        $error("unexpected result transfer: pc_value %h", rsp_ch.pc_value);
        error_count++;
      end else begin
        want = expected_responses.pop_front();
        if (rsp_ch.read_data !== want.read_data) begin
          $error("read_data: expected %h, actual %h", want.read_data, rsp_ch.read_data);
          error_count++;
        end
        if (rsp_ch.pc_value !== want.pc_value) begin
          $error("pc_value: expected %h, actual %h", want.pc_value, rsp_ch.pc_value);
          error_count++;
        end
        if (rsp_ch.halted !== want.halted) begin
          $error("halted: expected %b, actual %b", want.halted, rsp_ch.halted);
          error_count++;
        end
        if (rsp_ch.fault !== want.fault) begin
          $error("fault: expected %b, actual %b", want.fault, rsp_ch.fault);
          error_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // host writes and reads at the field extremes, wrap at the top of memory
  task automatic test_host_access();
    send_request(mss_pkg::REQ_READ_REG, '0, '0, 5'd31);
    send_request(mss_pkg::REQ_WRITE_WORD, 12'hFFF, 32'hFFFF_FFFF, 5'd0);
    send_request(mss_pkg::REQ_READ_WORD, 12'hFFE, 32'h0000_0000, 5'd31);
    send_request(REQ_UNUSED_HI, 12'hFFF, 32'hFFFF_FFFF, 5'd31);
    send_request(REQ_UNUSED_LO, 12'h000, 32'h0000_0000, 5'd0);
    send_request(mss_pkg::REQ_WRITE_WORD, 12'h800, 32'h8000_0080, 5'd0);
  endtask

  // every operation once, from a start address that wraps after one word
  task automatic test_instruction_set();
    logic [mss_pkg::ADDR_W-1:0] addr [9];
    logic [mss_pkg::WORD_W-1:0] code [9];
    addr = '{12'hFFC, 12'h000, 12'h004, 12'h008, 12'h00C,
             12'h014, 12'h018, 12'h020, 12'h024};
    code = '{{mss_pkg::OP_LW, 5'd0, 5'd2, 16'h0800},                    // negative word
             {mss_pkg::OP_ADD_LB, 5'd0, 5'd3, 16'h0800},                // sign-extended byte
             {mss_pkg::OP_SPECIAL, 5'd2, 5'd3, 5'd4, 5'd0, mss_pkg::OP_ADD_LB},
             {mss_pkg::OP_ADDI, 5'd0, 5'd5, 16'hFFFF},
             {mss_pkg::OP_BGE, 5'd5, 5'd2, 16'd1},                      // signed, taken
             {mss_pkg::OP_SW, 5'd0, 5'd4, 16'h0804},
             {mss_pkg::OP_J, 26'd8},
             {mss_pkg::OP_SPECIAL, 5'd0, 5'd6, 10'h155, mss_pkg::OP_LI}, // funct as selector
             {OP_UNKNOWN, 26'h3FF_FFFF}};
    write_code_start(12'hFFC);
    for (int i = 0; i < 9; i++)
      send_request(mss_pkg::REQ_WRITE_WORD, addr[i], code[i], 5'd0);
    send_random_fields(mss_pkg::REQ_START);
    // the step on the unknown selector faults, the one after it must do nothing
    repeat (10) send_random_fields(mss_pkg::REQ_STEP);
    send_request(mss_pkg::REQ_READ_REG, 12'h000, 32'h0, 5'd4);
    send_request(mss_pkg::REQ_READ_WORD, 12'h804, 32'h0, 5'd0);
  endtask

  // zero fetch halts, a halted step is ignored, start clears the flag
  task automatic test_halt();
    write_code_start(12'h900);
    send_random_fields(mss_pkg::REQ_START);
    send_random_fields(mss_pkg::REQ_STEP);
    send_random_fields(mss_pkg::REQ_STEP);
    send_random_fields(mss_pkg::REQ_START);
  endtask

  // long result stall while requests keep coming
  task automatic test_backpressure();
    -> hold_start;
    repeat (12) begin
      case ($urandom_range(2))
        0:       send_random_fields(mss_pkg::REQ_WRITE_WORD);
        1:       send_random_fields(mss_pkg::REQ_READ_WORD);
        default: send_random_fields(mss_pkg::REQ_READ_REG);
      endcase
    end
  endtask

  // load a program at the code start, then mostly step it with some noise
  task automatic run_program(input int words, input int steps);
    logic [mss_pkg::ADDR_W-1:0] base;
    int                         pick;
    base = code_start_reg;
    for (int i = 0; i < words; i++)
      send_request(mss_pkg::REQ_WRITE_WORD, base + mss_pkg::ADDR_W'(4 * i),
                   random_instruction(base, words), mss_pkg::SEL_W'($urandom));
    if ($urandom_range(9) != 0) send_random_fields(mss_pkg::REQ_START);
    for (int i = 0; i < steps; i++) begin
      pick = $urandom_range(99);
      if (pick < 72) begin
        send_random_fields(mss_pkg::REQ_STEP);
      end else if (pick < 82) begin
        send_random_fields(mss_pkg::REQ_READ_REG);
      end else if (pick < 86) begin
        send_request(mss_pkg::REQ_READ_WORD,
                     base + mss_pkg::ADDR_W'(4 * $urandom_range(words)),
                     $urandom, mss_pkg::SEL_W'($urandom));
      end else if (pick < 90) begin
        send_random_fields(mss_pkg::REQ_READ_WORD);
      end else if (pick < 94) begin
        send_random_fields(mss_pkg::REQ_WRITE_WORD);
      end else if (pick < 97) begin
        send_random_fields(mss_pkg::REQ_START);
      end else begin
        send_random_fields(mss_pkg::REQ_W'($urandom_range(REQ_UNUSED_HI, REQ_UNUSED_LO)));
      end
    end
  endtask

  task automatic test_random_programs();
    logic [mss_pkg::ADDR_W-1:0] start_addr;
    int                         phase;
    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      case (phase % 6)
        0:       start_addr = 12'h000;
        1:       start_addr = 12'hFFF;
        2:       start_addr = 12'hFFC;
        3, 4:    start_addr = mss_pkg::ADDR_W'($urandom_range(1023) * 4);
        default: start_addr = mss_pkg::ADDR_W'($urandom);
      endcase
      write_code_start(start_addr);
      // two phases run with no idle cycles on either side
      gap_pct = (phase == 3 || phase == 4) ? 0 : 10;
      repeat (3) run_program($urandom_range(12, 2), $urandom_range(30, 4));
      phase++;
    end
    gap_pct = 10;
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n              <= 1'b0;
    req_ch.valid       <= 1'b0;
    req_ch.req_type    <= mss_pkg::REQ_WRITE_WORD;
    req_ch.mem_address <= '0;
    req_ch.write_data  <= '0;
    req_ch.reg_select  <= '0;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.code_start  <= '0;

    // reset state of the behavioural copy
    for (int i = 0; i < mss_pkg::MEM_BYTES; i++) core_mem[i] = '0;
    for (int i = 0; i < mss_pkg::NUM_REGS; i++) core_regs[i] = '0;
    core_pc        = '0;
    core_halted    = 1'b0;
    core_faulted   = 1'b0;
    code_start_reg = '0;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    test_host_access();
    test_instruction_set();
    test_halt();
    test_backpressure();
    test_random_programs();

    drain_responses();
    repeat (20) @(posedge clk);
    if (error_count == 0)
      $display("tb_mips_subset_cpu_step: clean");
    else
      $display("tb_mips_subset_cpu_step: errors");
    $finish;
  end

  // run limit
  initial begin
    #10_000_000;
    $display("tb_mips_subset_cpu_step: errors");
    $finish;
  end

endmodule
